// File: hdl/mnst_pkg.sv
// mnst_pkg: shared types and constants for the midi note state tracker
// request codes, controller-to-datapath command struct, note-to-channel table
// no dependencies
package mnst_pkg;

  localparam int NOTE_COUNT      = 128;
  localparam int WORD_BITS       = 32;
  localparam int WORD_COUNT      = NOTE_COUNT / WORD_BITS;
  localparam int NOTE_W          = 7;
  localparam int VEL_W           = 7;
  localparam int CHAN_W          = 4;
  localparam int CHAN_OUT_W      = 8;
  localparam int STORE_W         = VEL_W + CHAN_W;
  localparam int CHANNEL_MODULUS = 12;
  localparam logic [CHAN_OUT_W-1:0] INVALID_CHANNEL = 8'd255;

  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_SNAPSHOT = 2'd2,
    REQ_QUERY    = 2'd3
  } req_t;

  typedef struct packed {
    logic       note_on;
    logic       note_off;
    logic       query_rd;
    logic       query_out;
    logic       snap_out;
    logic [1:0] word;
    logic       last;
  } dp_cmd_t;

  typedef logic [NOTE_COUNT-1:0][CHAN_W-1:0] mod_table_t;

  // note modulo the channel modulus, worked out at elaboration
  function automatic mod_table_t build_mod_table();
    mod_table_t t;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      t[i] = CHAN_W'(i % CHANNEL_MODULUS);
    end
    return t;
  endfunction

  localparam mod_table_t MOD_TABLE = build_mod_table();

endpackage

// File: hdl/midi_note_state_tracker.sv
// midi_note_state_tracker: top level, held-note map with per-note velocity and channel
// depends on mnst_pkg, mnst_ctrl, mnst_dp (which holds mnst_ram)
//
//   channel   ports                                            handshake
//   request   req_type note_number note_velocity               start & !busy
//             use_given_channel given_channel
//   result    channel_out velocity_out word_index              result_strobe, one cycle
//             change_bits held_bits last_of_run
//   config    cfg_data                                         cfg_write
//
// note on/off: one beat in the cycle after acceptance, busy stays low
// query: one beat, presented from the result register after the store's registered read
// snapshot: four beats back to back, after the state register and the result register
// busy stays high while a query or snapshot runs and drops with its last beat, so the next
//   request is taken during the last beat
// reset is synchronous and clears the maps and mode, the store needs no clearing pass
// results cannot be stalled by the receiver
module midi_note_state_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [6:0]  note_number,
  input  logic [6:0]  note_velocity,
  input  logic        use_given_channel,
  input  logic [3:0]  given_channel,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic        result_strobe,
  output logic [7:0]  channel_out,
  output logic [6:0]  velocity_out,
  output logic [1:0]  word_index,
  output logic [31:0] change_bits,
  output logic [31:0] held_bits,
  output logic        last_of_run
);
  import mnst_pkg::*;

  dp_cmd_t cmd;

  mnst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .busy    (busy),
    .cmd     (cmd)
  );

  mnst_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .note_number      (note_number),
    .note_velocity    (note_velocity),
    .use_given_channel(use_given_channel),
    .given_channel    (given_channel),
    .result_strobe    (result_strobe),
    .channel_out      (channel_out),
    .velocity_out     (velocity_out),
    .word_index       (word_index),
    .change_bits      (change_bits),
    .held_bits        (held_bits),
    .last_of_run      (last_of_run)
  );

  // a query answers with a single final beat after the store read, with no beat before it
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |=> !result_strobe ##1
      (result_strobe && last_of_run))
    else $error("query result timing wrong");

  // snapshot words come back to back in order
  assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_of_run) |=>
      (result_strobe && word_index == $past(word_index) + 2'd1))
    else $error("snapshot word sequence broken");

  // a beat that is not the last one only occurs mid-snapshot
  assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_of_run) |-> busy)
    else $error("non-final beat outside a snapshot");

  // an accepted snapshot starts with word zero, with no beat before it
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_SNAPSHOT) |=> !result_strobe ##1
      (result_strobe && word_index == 2'd0 && !last_of_run))
    else $error("snapshot did not start at word zero");

endmodule

// File: hdl/mnst_ram.sv
// mnst_ram: generic single-write, single-read ram with registered read data
// no dependencies
module mnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mnst_ctrl.sv
// mnst_ctrl: request sequencer for the note state tracker
// depends on mnst_pkg (req_t, dp_cmd_t)
module mnst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  output logic              busy,
  output mnst_pkg::dp_cmd_t cmd
);
  import mnst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SNAP
  } state_t;

  state_t     state;
  logic [1:0] word;
  logic       accept;
  req_t       req;

  assign req    = req_t'(req_type);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd           = '0;
    cmd.note_on   = accept && (req == REQ_NOTE_ON);
    cmd.note_off  = accept && (req == REQ_NOTE_OFF);
    cmd.query_rd  = accept && (req == REQ_QUERY);
    cmd.query_out = (state == ST_QUERY);
    cmd.snap_out  = (state == ST_SNAP);
    cmd.word      = word;
    cmd.last      = (word == 2'(WORD_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      word  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          word <= '0;
          if (accept && req == REQ_QUERY) begin
            state <= ST_QUERY;
          end else if (accept && req == REQ_SNAPSHOT) begin
            state <= ST_SNAP;
          end
        end
        ST_QUERY: begin
          state <= ST_IDLE;
        end
        ST_SNAP: begin
          word <= word + 2'd1;
          if (word == 2'(WORD_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/mnst_dp.sv
// mnst_dp: note maps, velocity/channel store and result registers
// depends on mnst_pkg and mnst_ram
module mnst_dp (
  input  logic              clk,
  input  logic              rst,
  input  mnst_pkg::dp_cmd_t cmd,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic [6:0]        note_number,
  input  logic [6:0]        note_velocity,
  input  logic              use_given_channel,
  input  logic [3:0]        given_channel,
  output logic              result_strobe,
  output logic [7:0]        channel_out,
  output logic [6:0]        velocity_out,
  output logic [1:0]        word_index,
  output logic [31:0]       change_bits,
  output logic [31:0]       held_bits,
  output logic              last_of_run
);
  import mnst_pkg::*;

  logic [WORD_COUNT-1:0][WORD_BITS-1:0] held_map;
  logic [WORD_COUNT-1:0][WORD_BITS-1:0] previous_map;
  logic                                 mode;
  logic                                 q_held;
  logic [CHAN_W-1:0]                    chan;
  logic                                 held_bit;
  logic [STORE_W-1:0]                   rd_data;

  // held bit doubles as the store's valid bit: a note not held reads as cleared
  assign held_bit = held_map[note_number[6:5]][note_number[4:0]];

  always_comb begin
    if (use_given_channel) begin
      chan = given_channel;
    end else if (mode) begin
      chan = MOD_TABLE[note_number];
    end else begin
      chan = '0;
    end
  end

  mnst_ram #(
    .WIDTH(STORE_W),
    .DEPTH(NOTE_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (cmd.note_on),
    .waddr(note_number),
    .wdata({note_velocity, chan}),
    .re   (cmd.query_rd),
    .raddr(note_number),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_map      <= '0;
      previous_map  <= '0;
      mode          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (cmd.note_on) begin
        held_map[note_number[6:5]][note_number[4:0]] <= 1'b1;
      end
      if (cmd.note_off) begin
        held_map[note_number[6:5]][note_number[4:0]] <= 1'b0;
      end
      if (cmd.snap_out) begin
        previous_map[cmd.word] <= held_map[cmd.word];
      end
      result_strobe <= cmd.note_on || cmd.note_off || cmd.query_out || cmd.snap_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_rd) begin
      q_held <= held_bit;
    end
    if (cmd.note_on || cmd.note_off) begin
      channel_out  <= CHAN_OUT_W'(chan);
      velocity_out <= '0;
      word_index   <= '0;
      change_bits  <= '0;
      held_bits    <= '0;
      last_of_run  <= 1'b1;
    end else if (cmd.query_out) begin
      channel_out  <= q_held ? CHAN_OUT_W'(rd_data[CHAN_W-1:0]) : INVALID_CHANNEL;
      velocity_out <= q_held ? rd_data[STORE_W-1:CHAN_W] : '0;
      word_index   <= '0;
      change_bits  <= '0;
      held_bits    <= '0;
      last_of_run  <= 1'b1;
    end else if (cmd.snap_out) begin
      channel_out  <= '0;
      velocity_out <= '0;
      word_index   <= cmd.word;
      change_bits  <= held_map[cmd.word] ^ previous_map[cmd.word];
      held_bits    <= held_map[cmd.word];
      last_of_run  <= cmd.last;
    end
  end

endmodule

// File: verif/midi_note_state_tracker_tb.sv
// midi_note_state_tracker_tb: self-checking bench for the held-note tracker
// a queue-fed driver sends on/off/snapshot/query requests; a monitor checks each result
// beat against an in-bench predictor of the note maps and stores; depends on mnst_pkg
module midi_note_state_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 70;

  typedef struct {
    req_t       kind;
    logic [6:0] note;
    logic [6:0] vel;
    logic       use_given;
    logic [3:0] given;
  } note_req_t;

  typedef struct {
    logic [7:0]  channel;
    logic [6:0]  velocity;
    logic [1:0]  word;
    logic [31:0] change;
    logic [31:0] held;
    logic        last;
  } note_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [6:0]  note_number = '0;
  logic [6:0]  note_velocity = '0;
  logic        use_given_channel = 1'b0;
  logic [3:0]  given_channel = '0;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        result_strobe;
  logic [7:0]  channel_out;
  logic [6:0]  velocity_out;
  logic [1:0]  word_index;
  logic [31:0] change_bits;
  logic [31:0] held_bits;
  logic        last_of_run;

  midi_note_state_tracker dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .note_number      (note_number),
    .note_velocity    (note_velocity),
    .use_given_channel(use_given_channel),
    .given_channel    (given_channel),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .result_strobe    (result_strobe),
    .channel_out      (channel_out),
    .velocity_out     (velocity_out),
    .word_index       (word_index),
    .change_bits      (change_bits),
    .held_bits        (held_bits),
    .last_of_run      (last_of_run)
  );

  // predictor state
  logic [3:0][31:0] held_words;
  logic [3:0][31:0] snap_words;
  logic [6:0]       vel_mem [NOTE_COUNT];
  logic [7:0]       chan_mem [NOTE_COUNT];
  logic             chan_mode;

  note_req_t  pending_reqs[$];
  note_beat_t expected_beats[$];
  note_req_t  cur_req;
  int         idle_pct = 0;
  int         in_flight = 0;
  bit         drain_hold = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] resolve_channel(note_req_t r);
    if (r.use_given) return {4'd0, r.given};
    if (chan_mode) return 8'(r.note % CHANNEL_MODULUS);
    return 8'd0;
  endfunction

  function automatic note_beat_t make_beat(logic [7:0] ch, logic [6:0] v, logic [1:0] w,
                                           logic [31:0] chg, logic [31:0] hd, logic lst);
    note_beat_t b;
    b.channel  = ch;
    b.velocity = v;
    b.word     = w;
    b.change   = chg;
    b.held     = hd;
    b.last     = lst;
    return b;
  endfunction

  // advance the note maps for one accepted request and queue the beats it yields
  task automatic track_request(note_req_t r);
    logic [7:0]  ch;
    logic [31:0] chg;
    case (r.kind)
      REQ_NOTE_ON: begin
        ch = resolve_channel(r);
        held_words[r.note[6:5]][r.note[4:0]] = 1'b1;
        vel_mem[r.note] = r.vel;
        chan_mem[r.note] = ch;
        expected_beats.push_back(make_beat(ch, '0, '0, '0, '0, 1'b1));
      end
      REQ_NOTE_OFF: begin
        ch = resolve_channel(r);
        held_words[r.note[6:5]][r.note[4:0]] = 1'b0;
        vel_mem[r.note] = '0;
        chan_mem[r.note] = INVALID_CHANNEL;
        expected_beats.push_back(make_beat(ch, '0, '0, '0, '0, 1'b1));
      end
      REQ_SNAPSHOT: begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          chg = held_words[k] ^ snap_words[k];
          snap_words[k] = held_words[k];
          expected_beats.push_back(make_beat('0, '0, 2'(k), chg, held_words[k], k == 3));
        end
      end
      default: begin
        expected_beats.push_back(make_beat(chan_mem[r.note], vel_mem[r.note], '0, '0, '0,
                                           1'b1));
      end
    endcase
  endtask

  // driver: start stays up until the request is accepted
  always @(posedge clk) begin
    logic accepted;
    logic launch;
    if (rst) begin
      start <= 1'b0;
      in_flight = 0;
      drain_hold = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        track_request(cur_req);
        in_flight++;
        if ($urandom_range(0, 24) == 0) drain_hold = 1;
      end
      if (result_strobe && last_of_run) in_flight--;
      if (drain_hold && in_flight <= 0) drain_hold = 0;
      launch = (accepted || !start) && pending_reqs.size() != 0 && !drain_hold &&
               $urandom_range(0, 99) >= idle_pct;
      if (launch) begin
        cur_req = pending_reqs.pop_front();
        start <= 1'b1;
        req_type <= cur_req.kind;
        note_number <= cur_req.note;
        note_velocity <= cur_req.vel;
        use_given_channel <= cur_req.use_given;
        given_channel <= cur_req.given;
      end else if (accepted || !start) begin
        // junk on the fields while start is low
        start <= 1'b0;
        req_type <= 2'($urandom);
        note_number <= 7'($urandom);
        note_velocity <= 7'($urandom);
        use_given_channel <= 1'($urandom);
        given_channel <= 4'($urandom);
      end
    end
  end

  // monitor: results cannot be held off, check every strobed beat
  always @(posedge clk) begin
    note_beat_t e;
    if (!rst && result_strobe) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: channel %0d word %0d", channel_out, word_index);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        if (channel_out !== e.channel) begin
          $error("channel_out: expected %0d, got %0d", e.channel, channel_out);
          mismatches++;
        end
        if (velocity_out !== e.velocity) begin
          $error("velocity_out: expected %0d, got %0d", e.velocity, velocity_out);
          mismatches++;
        end
        if (word_index !== e.word) begin
          $error("word_index: expected %0d, got %0d", e.word, word_index);
          mismatches++;
        end
        if (change_bits !== e.change) begin
          $error("change_bits: expected %h, got %h", e.change, change_bits);
          mismatches++;
        end
        if (held_bits !== e.held) begin
          $error("held_bits: expected %h, got %h", e.held, held_bits);
          mismatches++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  function automatic note_req_t make_req(req_t k, int n, int v, int ug, int g);
    note_req_t r;
    r.kind      = k;
    r.note      = 7'(n);
    r.vel       = 7'(v);
    r.use_given = 1'(ug);
    r.given     = 4'(g);
    return r;
  endfunction

  // mostly notes from a narrow window so offs and queries hit held notes
  function automatic note_req_t random_req(int base);
    int   pick;
    int   n;
    req_t k;
    pick = $urandom_range(0, 99);
    if (pick < 35) k = REQ_NOTE_ON;
    else if (pick < 65) k = REQ_NOTE_OFF;
    else if (pick < 75) k = REQ_SNAPSHOT;
    else k = REQ_QUERY;
    if ($urandom_range(0, 9) < 7) n = base + $urandom_range(0, 15);
    else n = $urandom_range(0, 127);
    return make_req(k, n, $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 15));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || expected_beats.size() != 0 || start);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    chan_mode = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int phase_idle [5];
    phase_idle = '{0, 81, 0, 33, 81};
    held_words = '0;
    snap_words = '0;
    chan_mode = 1'b0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      vel_mem[i] = '0;
      chan_mem[i] = INVALID_CHANNEL;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(1'b0);
    // untouched notes, extreme fields, word boundaries, repeated on, off of an idle note
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 127, 127, 1, 15));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 0, 127, 1, 15));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 127, 0, 0, 9));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 31, 85, 0, 0));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 32, 42, 1, 10));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 64, 1, 1, 5));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 96, 100, 0, 3));
    pending_reqs.push_back(make_req(REQ_SNAPSHOT, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 0, 1, 1, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 127, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_NOTE_OFF, 0, 33, 1, 5));
    pending_reqs.push_back(make_req(REQ_NOTE_OFF, 50, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 50, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SNAPSHOT, 127, 127, 1, 15));
    pending_reqs.push_back(make_req(REQ_SNAPSHOT, 0, 0, 0, 0));
    wait_idle();

    // derived channel per note
    write_mode(1'b1);
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 11, 64, 0, 15));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 12, 65, 0, 0));
    pending_reqs.push_back(make_req(REQ_NOTE_ON, 127, 127, 0, 0));
    pending_reqs.push_back(make_req(REQ_NOTE_OFF, 13, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 127, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_QUERY, 11, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SNAPSHOT, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      int base;
      write_mode(p % 2 == 0);
      idle_pct = phase_idle[p];
      base = $urandom_range(0, 112);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_reqs.push_back(random_req(base));
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d result beats never arrived", expected_beats.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mnst_pkg.sv
hdl/mnst_ram.sv
hdl/mnst_ctrl.sv
hdl/mnst_dp.sv
hdl/midi_note_state_tracker.sv
verif/midi_note_state_tracker_tb.sv
